// ----- src/rtfmt_pkg.sv -----
package rtfmt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [63:0] token_high;
    logic [63:0] token_low;
  } req_t;

  typedef struct packed {
    logic                   matched;
    logic                   evicted;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

endpackage

// ----- src/reset_token_fifo_match_table_core.sv -----
// reset token match table
// keeps up to TABLE_DEPTH 128-bit tokens in a ring; each request is an add
// or a lookup of one token
// input channel: in_valid_i / in_ready_o with an rtfmt_pkg::req_t beat
// output channel: out_valid_o / out_ready_i with an rtfmt_pkg::rsp_t beat,
// exactly one response beat per request beat
// every request walks all TABLE_DEPTH slots through one 128-bit comparator,
// one slot per cycle, whatever the fill level, so timing does not depend on
// the token or the hit position
// the response is registered once the scan has passed every slot and the
// ST_LAST step has settled the result; a new request is taken only after the
// response to the last one has been taken, so requests never overlap, and the
// pace is set by the slot scan through the single table read port
// in_ready_o is high only while the block is idle and its response register
// is empty, so a stalled receiver holds the block with the response steady
// reset empties the table (count and oldest pointer cleared); the token
// store itself is not cleared, slots are only compared once written
module reset_token_fifo_match_table_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rtfmt_pkg::req_t    in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rtfmt_pkg::rsp_t    out_rsp_o
);
  import rtfmt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  logic [63:0] mem_hi [TABLE_DEPTH];
  logic [63:0] mem_lo [TABLE_DEPTH];

  logic [1:0]       state_q, state_d;
  req_t             req_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] oldest_q, oldest_d;
  logic             hit_q, hit_d;
  logic             cmp_v_q, cmp_v_d;
  logic [63:0]      rd_hi_q, rd_lo_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic             cur_match;
  logic             hit_now;
  logic             do_write;
  logic [IDX_W-1:0] wr_slot;
  logic [CNT_W:0]   app_sum;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign cur_match = cmp_v_q && (rd_hi_q == req_q.token_high) && (rd_lo_q == req_q.token_low);
  assign hit_now   = hit_q | cur_match;
  assign do_write  = (state_q == ST_LAST) && (req_q.req_type == REQ_ADD) && !hit_now;

  // slot after the newest entry
  assign app_sum = {1'b0, CNT_W'(oldest_q)} + {1'b0, count_q};

  always_comb begin
    if (count_q == FULL_COUNT) begin
      wr_slot = oldest_q;
    end else if (app_sum >= (CNT_W + 1)'(TABLE_DEPTH)) begin
      wr_slot = IDX_W'(app_sum - (CNT_W + 1)'(TABLE_DEPTH));
    end else begin
      wr_slot = IDX_W'(app_sum);
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    count_d     = count_q;
    oldest_d    = oldest_q;
    hit_d       = hit_q;
    cmp_v_d     = 1'b0;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cnt_ext     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          addr_d  = oldest_q;
          hit_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        hit_d   = hit_now;
        cmp_v_d = {{(CNT_W - IDX_W){1'b0}}, idx_q} < count_q;
        addr_d  = (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = ST_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_LAST: begin
        out_d.matched = hit_now;
        out_d.evicted = 1'b0;
        if (do_write) begin
          if (count_q == FULL_COUNT) begin
            oldest_d      = (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;
            out_d.evicted = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        cnt_ext           = {{COUNT_OUT_W{1'b0}}, count_d};
        out_d.entry_count = cnt_ext[COUNT_OUT_W-1:0];
        out_valid_d       = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      addr_q      <= '0;
      count_q     <= '0;
      oldest_q    <= '0;
      hit_q       <= 1'b0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      addr_q      <= addr_d;
      count_q     <= count_d;
      oldest_q    <= oldest_d;
      hit_q       <= hit_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    out_q <= out_d;
  end

  // token store, one read port for the scan and one write port
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_hi[wr_slot] <= req_q.token_high;
      mem_lo[wr_slot] <= req_q.token_low;
    end
    rd_hi_q <= mem_hi[addr_q];
    rd_lo_q <= mem_lo[addr_q];
  end

endmodule
